>>> design/grouped_decimal_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grouped decimal formatter.
// Each macro checks an implication on the rising edge of clk, with the
// check held off during reset.
// ----------------------------------------------------------------------------
`ifndef GROUPED_DECIMAL_FORMATTER_ASSERT_SVH
`define GROUPED_DECIMAL_FORMATTER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GDF_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("grouped_decimal_formatter: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define GDF_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("grouped_decimal_formatter: next-cycle check failed");

`endif

>>> design/gdf_pkg.sv
// ----------------------------------------------------------------------------
// gdf_pkg
// Types and constants shared by the grouped decimal formatter modules.
// ----------------------------------------------------------------------------
package gdf_pkg;

	// Width of the binary input and of the packed decimal result.
	localparam int BIN_W  = 64;
	localparam int DIGITS = 20;
	localparam int BCD_W  = 4 * DIGITS;

	// Longest text the block can hold, and the counter that walks it.
	localparam int MAX_TEXT = 27;
	localparam int CNT_W    = $clog2(MAX_TEXT + 1);

	// Width of the count of significant digits still to emit.
	localparam int REM_W = $clog2(DIGITS + 1);

	// Character codes.
	localparam logic [7:0] ASCII_ZERO  = 8'h30;
	localparam logic [7:0] ASCII_MINUS = 8'h2D;
	localparam logic [7:0] GROUP_RESET = 8'h2C;

	// Status of the binary-to-decimal unit.
	typedef struct packed {
		logic busy;
		logic done;
	} gdf_conv_status_t;

endpackage

>>> design/gdf_bcd_unit.sv
// ----------------------------------------------------------------------------
// gdf_bcd_unit
// Iterative binary-to-decimal converter: one shift-and-add-three step
// per cycle.
// ----------------------------------------------------------------------------
module gdf_bcd_unit
	import gdf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [BIN_W-1:0]       mag,
	output gdf_conv_status_t       status,
	output logic [BCD_W-1:0]       bcd
);

	localparam int STEP_W = $clog2(BIN_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BIN_W - 1);

	logic [BIN_W-1:0]  bin_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [BCD_W-1:0]  adj;

	// Every digit of five or more gets three added before the shift.
	always_comb begin
		for (int d = 0; d < DIGITS; d++) begin
			if (bcd_q[4*d +: 4] >= 4'd5) begin
				adj[4*d +: 4] = bcd_q[4*d +: 4] + 4'd3;
			end else begin
				adj[4*d +: 4] = bcd_q[4*d +: 4];
			end
		end
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == LAST_STEP);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Data path: shift the binary word into the decimal register.
	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
			bcd_q <= {adj[BCD_W-2:0], bin_q[BIN_W-1]};
		end
	end

	assign status = '{busy: busy_q, done: done_q};
	assign bcd    = bcd_q;

endmodule

>>> design/grouped_decimal_formatter.sv
// ----------------------------------------------------------------------------
// grouped_decimal_formatter
// Formats a signed 64-bit integer as grouped ASCII decimal text.
// ----------------------------------------------------------------------------
// Usage:
//   A request on the slave stream (s_tdata = value) is taken when the block
//   is idle. The block then streams the decimal text on the master stream,
//   one byte per transfer, most significant digit first, with a leading
//   minus for negative values and cfg_wdata's separator before every third
//   digit from the right. m_tlast marks the final byte; the text is cut
//   to min(OUTPUT_LIMIT - 1, MAX_TEXT) bytes (at most 26 are ever produced).
//   Steps: the shift-and-add-three unit converts the magnitude, the result
//   is handed over, leading zero digits are stripped one per cycle (up to
//   19), normalisation is left, then the first byte is loaded. Bytes follow
//   one per cycle while m_tready is high.
//   s_tready is high only while the block is idle; a new value may be
//   taken while the last byte of the previous text is still waiting.
//   When the receiver stalls, the output register holds its byte and the
//   sequencer waits. Reset clears all control state and sets the
//   separator to a comma.
// ----------------------------------------------------------------------------
`include "grouped_decimal_formatter_assert.svh"

module grouped_decimal_formatter
	import gdf_pkg::*;
#(
	parameter int OUTPUT_LIMIT = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	// Configuration: separator byte.
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	// Slave stream. s_tdata: [63:0] value.
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [BIN_W-1:0]   s_tdata,
	// Master stream. m_tdata: [7:0] char_out. m_tlast: last.
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,
	output logic               m_tlast
);

	localparam int CAP = ((OUTPUT_LIMIT - 1) > MAX_TEXT) ? MAX_TEXT : (OUTPUT_LIMIT - 1);
	localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(CAP - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_CONV,
		S_NORM,
		S_EMIT
	} state_t;

	state_t            state_q;
	logic [7:0]        group_char_q;
	logic              sign_pending_q;
	logic              sep_done_q;
	logic              first_q;
	logic [BCD_W-1:0]  bcd_q;
	logic [REM_W-1:0]  rem_q;
	logic [1:0]        mod3_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              m_tvalid_q;
	logic [7:0]        m_tdata_q;
	logic              m_tlast_q;

	logic              accept;
	logic [BIN_W-1:0]  mag;
	gdf_conv_status_t  conv_st;
	logic [BCD_W-1:0]  conv_bcd;

	logic              load;
	logic [7:0]        next_char;
	logic              next_digit;
	logic              next_last;
	logic [1:0]        mod3_dec;

	assign accept = s_tvalid && s_tready;

	// Magnitude in unsigned arithmetic, so the most negative value is exact.
	assign mag = s_tdata[BIN_W-1] ? (~s_tdata + 1'b1) : s_tdata;

	gdf_bcd_unit u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.status (conv_st),
		.bcd    (conv_bcd)
	);

	// Remaining digit count modulo three, counted down.
	assign mod3_dec = (mod3_q == 2'd0) ? 2'd2 : (mod3_q - 2'd1);

	// Choice of the next byte: sign, then separator, then digit.
	always_comb begin
		next_digit = 1'b0;
		if (sign_pending_q) begin
			next_char = ASCII_MINUS;
		end else if (!first_q && (mod3_q == 2'd0) && !sep_done_q) begin
			next_char = group_char_q;
		end else begin
			next_char  = ASCII_ZERO + {4'd0, bcd_q[BCD_W-1 -: 4]};
			next_digit = 1'b1;
		end
		next_last = (next_digit && (rem_q == REM_W'(1))) || (cnt_q == LAST_IDX);
	end

	assign load = (state_q == S_EMIT) && (!m_tvalid_q || m_tready);

	// Separator register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_char_q <= GROUP_RESET;
		end else if (cfg_we) begin
			group_char_q <= cfg_wdata;
		end
	end

	// Sequencer with the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			sign_pending_q <= 1'b0;
			sep_done_q     <= 1'b0;
			first_q        <= 1'b0;
			rem_q          <= '0;
			mod3_q         <= '0;
			cnt_q          <= '0;
			m_tvalid_q     <= 1'b0;
			m_tdata_q      <= '0;
			m_tlast_q      <= 1'b0;
		end else begin
			// The output byte is valid from its load until the receiver takes it.
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						sign_pending_q <= s_tdata[BIN_W-1];
						state_q        <= S_CONV;
					end
				end
				S_CONV: begin
					if (conv_st.done) begin
						rem_q      <= REM_W'(DIGITS);
						mod3_q     <= 2'(DIGITS % 3);
						first_q    <= 1'b1;
						sep_done_q <= 1'b0;
						cnt_q      <= '0;
						state_q    <= S_NORM;
					end
				end
				S_NORM: begin
					// Strip one leading zero digit per cycle, keeping at least one.
					if ((bcd_q[BCD_W-1 -: 4] == 4'd0) && (rem_q != REM_W'(1))) begin
						rem_q  <= rem_q - 1'b1;
						mod3_q <= mod3_dec;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						m_tdata_q  <= next_char;
						m_tlast_q  <= next_last;
						cnt_q      <= cnt_q + 1'b1;
						if (sign_pending_q) begin
							sign_pending_q <= 1'b0;
						end else if (!next_digit) begin
							sep_done_q <= 1'b1;
						end else begin
							rem_q      <= rem_q - 1'b1;
							mod3_q     <= mod3_dec;
							first_q    <= 1'b0;
							sep_done_q <= 1'b0;
						end
						if (next_last) begin
							state_q <= S_IDLE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Decimal working register: loaded from the unit, shifted one digit at a time.
	always_ff @(posedge clk) begin
		if ((state_q == S_CONV) && conv_st.done) begin
			bcd_q <= conv_bcd;
		end else if ((state_q == S_NORM) && (bcd_q[BCD_W-1 -: 4] == 4'd0)
				&& (rem_q != REM_W'(1))) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end else if (load && !sign_pending_q && next_digit) begin
			bcd_q <= {bcd_q[BCD_W-5:0], 4'd0};
		end
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Checks on the sequencer and the conversion unit.
	`GDF_ASSERT_NEXT(a_accept_starts_unit, accept, conv_st.busy)
	`GDF_ASSERT_NOW(a_done_only_in_conv, conv_st.done, state_q == S_CONV)
	`GDF_ASSERT_NOW(a_emit_has_digits, state_q == S_EMIT, rem_q != '0)
	`GDF_ASSERT_NOW(a_count_within_cap, state_q == S_EMIT, cnt_q <= LAST_IDX)

endmodule

>>> tb/sv/gdf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gdf_checker
// Watches both streams and the separator register of the grouped decimal
// formatter. For every value that is taken it works out the ASCII text the
// block should produce and queues it. Each byte leaving the block is then
// compared with the oldest queued byte, character and last flag apart.
// ----------------------------------------------------------------------------
module gdf_checker
	import gdf_pkg::*;
#(
	parameter int OUTPUT_LIMIT = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_wdata,
	input  logic             s_tvalid,
	input  logic             s_tready,
	// s_tdata: [63:0] value.
	input  logic [BIN_W-1:0] s_tdata,
	input  logic             m_tvalid,
	input  logic             m_tready,
	// m_tdata: [7:0] char_out.
	input  logic [7:0]       m_tdata,
	input  logic             m_tlast,
	output int               outstanding,
	output int               mismatches
);

	typedef struct {
		logic [7:0] char_out;
		logic       last;
	} text_byte_t;

	text_byte_t expected_text[$];
	logic [7:0] group_char;
	int         pending_chars = 0;
	int         fail_count    = 0;

	assign outstanding = pending_chars;
	assign mismatches  = fail_count;

	// Shadow of the separator register.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_char <= GROUP_RESET;
		end else if (cfg_we) begin
			group_char <= cfg_wdata;
		end
	end

	// Builds the grouped decimal text of one value and queues its bytes,
	// cut to the length the output buffer allows.
	function automatic void predict_text(input logic [BIN_W-1:0] value,
			input logic [7:0] sep);
		logic             neg;
		logic [BIN_W-1:0] mag;
		logic [3:0]       digs [0:DIGITS-1];
		logic [7:0]       text[$];
		int               nd;
		int               cap;
		int               n;
		text_byte_t       item;

		neg = value[BIN_W-1];
		// The most negative value wraps to its own bit pattern, which read as
		// unsigned is exactly its magnitude.
		mag = neg ? (~value + 64'd1) : value;
		nd  = 0;
		do begin
			digs[nd] = 4'(mag % 64'd10);
			nd++;
			mag = mag / 64'd10;
		end while (mag != 0 && nd < DIGITS);

		if (neg) begin
			text.push_back(ASCII_MINUS);
		end
		for (int p = 0; p < nd; p++) begin
			if (p > 0 && ((nd - p) % 3) == 0) begin
				text.push_back(sep);
			end
			text.push_back(ASCII_ZERO + 8'(digs[nd - 1 - p]));
		end

		cap = (OUTPUT_LIMIT > 1) ? OUTPUT_LIMIT - 1 : 0;
		if (cap > MAX_TEXT) begin
			cap = MAX_TEXT;
		end
		n = (text.size() < cap) ? text.size() : cap;
		for (int k = 0; k < n; k++) begin
			item.char_out = text[k];
			item.last     = (k == n - 1);
			expected_text.push_back(item);
		end
	endfunction

	// Prediction on each accepted value, comparison on each accepted byte.
	always @(posedge clk) begin
		text_byte_t want;

		if (arst_n && s_tvalid && s_tready) begin
			predict_text(s_tdata, group_char);
		end
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_text.size() == 0) begin
				fail_count++;
				$display("%0t: byte with nothing expected: expected none, got char %h last %b",
					$time, m_tdata, m_tlast);
			end else begin
				want = expected_text.pop_front();
				if (m_tdata !== want.char_out) begin
					fail_count++;
					$display("%0t: char_out mismatch: expected %h, got %h",
						$time, want.char_out, m_tdata);
				end
				if (m_tlast !== want.last) begin
					fail_count++;
					$display("%0t: last mismatch: expected %b, got %b",
						$time, want.last, m_tlast);
				end
			end
		end
		pending_chars <= expected_text.size();
	end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the grouped decimal formatter. A directed set of values covers
// zero, single digits, several grouping boundaries and both extremes of the
// signed range; random values of every magnitude then run under a series of
// separator settings, with random idling on both streams except in the third
// phase and the last two. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import gdf_pkg::*;

	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         PHASE_ITEMS  = 60;
	localparam int         PHASES       = 8;
	localparam logic [7:0] SEP_POINT    = 8'h2E;
	localparam logic [7:0] SEP_SPACE    = 8'h20;
	localparam logic [7:0] SEP_NUL      = 8'h00;
	localparam logic [7:0] SEP_ALL_ONES = 8'hFF;
	localparam logic [7:0] SEP_QUOTE    = 8'h27;
	localparam logic [BIN_W-1:0] MOST_NEG = 64'h8000_0000_0000_0000;
	localparam logic [BIN_W-1:0] MOST_POS = 64'h7FFF_FFFF_FFFF_FFFF;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             cfg_we    = 1'b0;
	logic [7:0]       cfg_wdata = 8'h00;
	logic             s_tvalid  = 1'b0;
	logic             s_tready;
	logic [BIN_W-1:0] s_tdata   = '0;
	logic             m_tvalid;
	logic             m_tready  = 1'b0;
	logic [7:0]       m_tdata;
	logic             m_tlast;
	int               outstanding;
	int               mismatches;

	// Idling controls: percentage chance of starting a gap or stall burst.
	int tx_gap_pct   = 20;
	int rx_stall_pct = 20;
	int stall_left   = 0;
	int cycle_count  = 0;

	grouped_decimal_formatter #(
		.OUTPUT_LIMIT(32)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	gdf_checker #(
		.OUTPUT_LIMIT(32)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	always #5 clk = ~clk;

	// Receiver: ready by default, with random stall bursts.
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (stall_left == 1) begin
			stall_left <= 0;
			m_tready   <= 1'b1;
		end else if ($urandom_range(0, 99) < rx_stall_pct) begin
			stall_left <= $urandom_range(1, 15);
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Run limit.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	// Offers one value, after an optional gap, and returns once it is taken.
	task automatic send_value(input logic [BIN_W-1:0] value);
		if ($urandom_range(0, 99) < tx_gap_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Waits until every predicted byte has left the block.
	task automatic wait_text_done();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	task automatic write_separator(input logic [7:0] sep);
		wait_text_done();
		cfg_we    <= 1'b1;
		cfg_wdata <= sep;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random value: full width, random magnitude, near a power of ten,
	// small, one of the extremes, zero or all ones; each is negated at random.
	function automatic logic [BIN_W-1:0] pick_value();
		logic [BIN_W-1:0] v;
		int               k;

		case ($urandom_range(0, 6))
			0: v = {$urandom(), $urandom()};
			1, 2: v = {$urandom(), $urandom()} >> $urandom_range(0, 63);
			3, 4: begin
				v = 64'd1;
				k = $urandom_range(0, 18);
				repeat (k) v = v * 64'd10;
				v = v + 64'($urandom_range(0, 2)) - 64'd1;
			end
			5: v = 64'($urandom_range(0, 2000));
			default: begin
				case ($urandom_range(0, 3))
					0: v = MOST_NEG;
					1: v = MOST_POS;
					2: v = '0;
					default: v = '1;
				endcase
			end
		endcase
		if ($urandom_range(0, 1) == 1) begin
			v = ~v + 64'd1;
		end
		return v;
	endfunction

	initial begin
		logic [BIN_W-1:0] directed [$];
		logic [7:0]       phase_sep [0:PHASES-1];

		directed = '{64'd0, 64'd1, '1, 64'd9, -64'sd9, 64'd10, 64'd99, 64'd100,
			64'd999, 64'd1000, -64'sd1000, 64'd12345, 64'd123456, 64'd1234567,
			-64'sd999999, 64'd1000000, 64'd1000000000000000000,
			64'd999999999999999999, -64'sd1000000000000000000,
			64'd10000000000000000000, MOST_POS, MOST_NEG};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed values with the reset separator.
		foreach (directed[i]) begin
			send_value(directed[i]);
		end

		// Separator extremes, on the longest texts and on shorter ones.
		write_separator(SEP_NUL);
		send_value(64'd1234567);
		send_value(MOST_NEG);
		write_separator(SEP_ALL_ONES);
		send_value(MOST_POS);
		send_value(-64'sd1234);

		// Random phases, each under its own separator. The third phase runs
		// without idling; the last two run without idling as the closing part.
		phase_sep = '{SEP_POINT, SEP_SPACE, SEP_QUOTE, SEP_NUL, 8'($urandom()),
			GROUP_RESET, 8'($urandom()), SEP_ALL_ONES};
		for (int p = 0; p < PHASES; p++) begin
			write_separator(phase_sep[p]);
			if (p == 2 || p >= PHASES - 2) begin
				tx_gap_pct   = 0;
				rx_stall_pct = 0;
			end else begin
				tx_gap_pct   = $urandom_range(5, 50);
				rx_stall_pct = $urandom_range(5, 50);
			end
			repeat (PHASE_ITEMS) send_value(pick_value());
		end

		wait_text_done();
		repeat (150) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
